/* rtl/ring_fifo_with_peek_macros.svh */
// Assertion helpers for the ring FIFO with peek.
// Define NO_ASSERTIONS to compile every check away.
`ifndef RING_FIFO_WITH_PEEK_MACROS_SVH
`define RING_FIFO_WITH_PEEK_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RFP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring fifo check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RFP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring fifo check failed");
`else
`define RFP_ASSERT_IMP(label, ante, cons)
`define RFP_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/rfp_pkg.sv */
package rfp_pkg;

  localparam int ELEM_W   = 32;
  localparam int MODE_W   = 2;
  localparam int OFFSET_W = 4;
  localparam int COUNT_W  = 4;
  localparam int CAPCFG_W = 5;

  localparam int DEPTH_DEF = 16;
  localparam int CAP_RESET = 16;

  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

  // Result status handed from the pointer logic to the result register.
  typedef struct packed {
    logic                ok;
    logic                rd_sel;
    logic [COUNT_W-1:0]  item_count;
    logic                is_empty;
    logic                is_full;
  } status_t;

endpackage

/* rtl/rfp_in_if.sv */
interface rfp_in_if;
  logic                          valid;
  logic                          ready;
  logic [rfp_pkg::MODE_W-1:0]    mode;
  logic [rfp_pkg::ELEM_W-1:0]    push_data;
  logic [rfp_pkg::OFFSET_W-1:0]  peek_offset;

  modport source (output valid, mode, push_data, peek_offset, input ready);
  modport sink   (input valid, mode, push_data, peek_offset, output ready);
endinterface

/* rtl/rfp_out_if.sv */
interface rfp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [rfp_pkg::ELEM_W-1:0]   out_data;
  logic [rfp_pkg::COUNT_W-1:0]  item_count;
  logic                         is_empty;
  logic                         is_full;

  modport source (output valid, ok, out_data, item_count, is_empty, is_full, input ready);
  modport sink   (input valid, ok, out_data, item_count, is_empty, is_full, output ready);
endinterface

/* rtl/rfp_mem.sv */
module rfp_mem #(
  parameter int DEPTH = rfp_pkg::DEPTH_DEF,
  parameter int W     = rfp_pkg::ELEM_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] store_r [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  // Read data is registered and holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/rfp_ctrl.sv */
`include "ring_fifo_with_peek_macros.svh"

module rfp_ctrl #(
  parameter int DEPTH = rfp_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [rfp_pkg::MODE_W-1:0]       mode,
  input  logic [rfp_pkg::OFFSET_W-1:0]     peek_offset,
  input  logic                             cfg_we,
  input  logic [rfp_pkg::CAPCFG_W-1:0]     cfg_wdata,
  output rfp_pkg::status_t                 status,
  output logic                             mem_we,
  output logic [$clog2(DEPTH)-1:0]         mem_waddr,
  output logic                             mem_re,
  output logic [$clog2(DEPTH)-1:0]         mem_raddr
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CAP_W = $clog2(DEPTH + 1);
  localparam int W     = CAP_W + 1;
  localparam int CAP_RST = (DEPTH < rfp_pkg::CAP_RESET) ? DEPTH : rfp_pkg::CAP_RESET;

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;

  logic [W-1:0] wp_e, rp_e, cap_e, off_e;
  logic [W-1:0] wp_inc, rp_inc, wp_wrap, rp_wrap;
  logic [W-1:0] count, cnt_after, peek_idx;
  logic         empty_now, full_now;
  logic         push_ok, pop_ok, peek_ok;
  logic [CAP_W-1:0] cap_cfg;

  assign wp_e  = W'(wp_r);
  assign rp_e  = W'(rp_r);
  assign cap_e = W'(cap_r);
  assign off_e = W'(peek_offset);

  assign wp_inc  = wp_e + 1'b1;
  assign rp_inc  = rp_e + 1'b1;
  assign wp_wrap = (wp_inc == cap_e) ? '0 : wp_inc;
  assign rp_wrap = (rp_inc == cap_e) ? '0 : rp_inc;

  assign count     = (wp_e >= rp_e) ? (wp_e - rp_e) : (wp_e + cap_e - rp_e);
  assign empty_now = (wp_e == rp_e);
  assign full_now  = (wp_wrap == rp_e);

  // The offset only matters when it is below the count, so the truncation
  // into W bits never changes a used index.
  assign peek_idx = (wp_e > off_e) ? (wp_e - 1'b1 - off_e)
                                   : (wp_e + cap_e - 1'b1 - off_e);

  always_comb begin
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    peek_ok = 1'b0;
    case (mode)
      rfp_pkg::MODE_PUSH: push_ok = !full_now;
      rfp_pkg::MODE_POP:  pop_ok  = !empty_now;
      rfp_pkg::MODE_PEEK: peek_ok = (32'(peek_offset) < 32'(count));
      default: ;
    endcase
  end

  assign cnt_after = push_ok ? (count + 1'b1) : (pop_ok ? (count - 1'b1) : count);

  assign status.ok         = push_ok | pop_ok | peek_ok;
  assign status.rd_sel     = pop_ok | peek_ok;
  assign status.item_count = rfp_pkg::COUNT_W'(cnt_after);
  assign status.is_empty   = (cnt_after == '0);
  assign status.is_full    = (cnt_after == (cap_e - 1'b1));

  assign mem_we    = accept & push_ok;
  assign mem_waddr = wp_r;
  assign mem_re    = accept;
  assign mem_raddr = (mode == rfp_pkg::MODE_POP) ? rp_r : PTR_W'(peek_idx);

  // Capacity is clamped to 2..DEPTH on the way in.
  always_comb begin
    if (cfg_wdata < 5'd2) begin
      cap_cfg = CAP_W'(2);
    end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
      cap_cfg = CAP_W'(DEPTH);
    end else begin
      cap_cfg = CAP_W'(cfg_wdata);
    end
  end

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cap_nxt = cap_r;
    if (cfg_we && empty_now) begin
      cap_nxt = cap_cfg;
      wp_nxt  = '0;
      rp_nxt  = '0;
    end else if (accept) begin
      if (push_ok) begin
        wp_nxt = PTR_W'(wp_wrap);
      end
      if (pop_ok) begin
        rp_nxt = PTR_W'(rp_wrap);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cap_r <= CAP_W'(CAP_RST);
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cap_r <= cap_nxt;
    end
  end

  `RFP_ASSERT_IMP(a_ptr_range, 1'b1, (wp_e < cap_e) && (rp_e < cap_e))
  `RFP_ASSERT_IMP(a_flags_apart, 1'b1, !(status.is_empty && status.is_full))
  `RFP_ASSERT_NXT(a_push_grows, accept && push_ok && !cfg_we, count == $past(count) + 1'b1)
  `RFP_ASSERT_NXT(a_reject_keeps, accept && !status.ok && !cfg_we, $stable(wp_r) && $stable(rp_r))

endmodule

/* rtl/ring_fifo_with_peek.sv */
// Ring FIFO with peek.
// Input channel in_ch carries one operation per beat: mode selects push, pop
// or peek, push_data is the element for a push and peek_offset counts back
// from the newest element (zero is the newest). Result channel out_ch returns
// exactly one beat per operation with ok, out_data (zero unless a pop or peek
// succeeded), and the count, empty and full status after the operation.
// The cfg_we / cfg_wdata port sets the wrap capacity, clamped to 2..DEPTH; a
// write takes effect only while the buffer is empty and also rewinds both
// pointers. At most capacity minus one elements are held.
// A result is valid the cycle after its operation is accepted. Throughput
// is one operation per cycle while results are taken, set by the single
// increment-and-wrap pointer update and the one registered read of the store.
// If the receiver stalls, the result register holds its beat and in_ch.ready
// drops only until that beat is taken; a new beat is accepted in the same
// cycle the old result leaves. Reset (rst_n low, synchronous) empties the
// buffer and sets the capacity to 16 (or DEPTH if smaller); the store itself
// is not cleared.
module ring_fifo_with_peek #(
  parameter int DEPTH = rfp_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rfp_in_if.sink                         in_ch,
  rfp_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rfp_pkg::CAPCFG_W-1:0]   cfg_wdata
);

  localparam int PTR_W = $clog2(DEPTH);

  logic                        accept;
  rfp_pkg::status_t            status;
  rfp_pkg::status_t            status_r, status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        mem_we, mem_re;
  logic [PTR_W-1:0]            mem_waddr, mem_raddr;
  logic [rfp_pkg::ELEM_W-1:0]  rd_data;

  // The result register is the only buffer between the two sides, so a new
  // beat may enter whenever that register is empty or is being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  rfp_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .mode        (in_ch.mode),
    .peek_offset (in_ch.peek_offset),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .status      (status),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr)
  );

  // The store read is registered on the same edge as the status, so its
  // output lines up with the result register and holds while stalled.
  rfp_mem #(
    .DEPTH (DEPTH),
    .W     (rfp_pkg::ELEM_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (in_ch.push_data),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = status;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Status is payload and needs no reset.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = status_r.ok;
  assign out_ch.out_data   = status_r.rd_sel ? rd_data : '0;
  assign out_ch.item_count = status_r.item_count;
  assign out_ch.is_empty   = status_r.is_empty;
  assign out_ch.is_full    = status_r.is_full;

endmodule

/* bench/ring_fifo_with_peek_tb.sv */
module ring_fifo_with_peek_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfp_pkg::*;

  // The mode encoding leaves one value unused; the block must answer it
  // with a failed, side-effect-free result.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Number of operations the random part aims for before it stops.
  localparam int TARGET_OPS = 1550;

  // One operation as it travels on the input channel.
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [ELEM_W-1:0]   push_data;
    logic [OFFSET_W-1:0] peek_offset;
  } fifo_op_t;

  // One result as it travels on the output channel.
  typedef struct packed {
    logic               ok;
    logic [ELEM_W-1:0]  out_data;
    logic [COUNT_W-1:0] item_count;
    logic               is_empty;
    logic               is_full;
  } fifo_status_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CAPCFG_W-1:0] cfg_wdata;

  rfp_in_if  in_ch ();
  rfp_out_if out_ch ();

  ring_fifo_with_peek uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns period: high and low halves of 10 ns each.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Shadow copy of the buffer. It follows every accepted operation and
  // every capacity write, and from it the expected result of each
  // operation is worked out at the moment the operation is accepted.
  // ------------------------------------------------------------------
  int                  shadow_wr;
  int                  shadow_rd;
  logic [CAPCFG_W-1:0] shadow_cap;
  logic [ELEM_W-1:0]   shadow_store [DEPTH_DEF];

  // The register holds any 5-bit value, but the pointers wrap over the
  // value clamped to 2..DEPTH.
  function automatic int shadow_cap_eff();
    if (shadow_cap < 2) return 2;
    if (shadow_cap > DEPTH_DEF) return DEPTH_DEF;
    return shadow_cap;
  endfunction

  function automatic int shadow_held();
    int cap;
    cap = shadow_cap_eff();
    return (shadow_wr + cap - shadow_rd) % cap;
  endfunction

  // Applies one operation to the shadow buffer and returns the result the
  // block must give for it. One slot is always left free, so the buffer
  // is full when advancing the write pointer would reach the read pointer.
  function automatic fifo_status_t apply_fifo_op(fifo_op_t op);
    fifo_status_t st;
    int           cap;
    int           nxt;
    cap = shadow_cap_eff();
    st  = '0;
    case (op.mode)
      MODE_PUSH: begin
        nxt = (shadow_wr + 1) % cap;
        // A push into a full buffer drops the element.
        if (nxt != shadow_rd) begin
          shadow_store[shadow_wr] = op.push_data;
          shadow_wr = nxt;
          st.ok = 1'b1;
        end
      end
      MODE_POP: begin
        // A pop from an empty buffer fails and changes nothing.
        if (shadow_rd != shadow_wr) begin
          st.out_data = shadow_store[shadow_rd];
          shadow_rd = (shadow_rd + 1) % cap;
          st.ok = 1'b1;
        end
      end
      MODE_PEEK: begin
        // Offset zero is the newest element; an offset at or past the
        // count fails.
        if (int'(op.peek_offset) < shadow_held()) begin
          st.out_data = shadow_store[(shadow_wr + 2 * cap - 1 - int'(op.peek_offset)) % cap];
          st.ok = 1'b1;
        end
      end
      default: begin
        // The unused mode only reports status.
      end
    endcase
    st.item_count = COUNT_W'(shadow_held());
    st.is_empty   = (shadow_held() == 0);
    st.is_full    = (((shadow_wr + 1) % cap) == shadow_rd);
    return st;
  endfunction

  // ------------------------------------------------------------------
  // Bookkeeping shared between the stimulus, the driver and the monitor.
  // ------------------------------------------------------------------
  fifo_op_t     pending_ops [$];     // operations not yet handed to the driver
  fifo_status_t awaited_status [$];  // results owed by the block, oldest first
  int           ops_queued;
  int           ops_accepted;
  int           fail_count;
  int           in_gap_max;
  int           out_stall_max;
  int           in_wait;
  int           out_stall;
  bit           in_beat_done;
  bit           res_beat_done;

  function automatic void check_field(string name, logic [ELEM_W-1:0] want,
                                      logic [ELEM_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // ------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge. A result beat is
  // checked before an input beat of the same edge is predicted, since a
  // result can never belong to an operation accepted at the same edge.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    fifo_status_t got;
    fifo_status_t want;
    fifo_op_t     op;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.ok         = out_ch.ok;
        got.out_data   = out_ch.out_data;
        got.item_count = out_ch.item_count;
        got.is_empty   = out_ch.is_empty;
        got.is_full    = out_ch.is_full;
        if (awaited_status.size() == 0) begin
          fail_count++;
          $display("%0t ns: result beat with nothing expected, got %p", $time, got);
        end else begin
          want = awaited_status.pop_front();
          check_field("ok", ELEM_W'(want.ok), ELEM_W'(got.ok));
          check_field("out_data", want.out_data, got.out_data);
          check_field("item_count", ELEM_W'(want.item_count), ELEM_W'(got.item_count));
          check_field("is_empty", ELEM_W'(want.is_empty), ELEM_W'(got.is_empty));
          check_field("is_full", ELEM_W'(want.is_full), ELEM_W'(got.is_full));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        op.mode        = in_ch.mode;
        op.push_data   = in_ch.push_data;
        op.peek_offset = in_ch.peek_offset;
        awaited_status.push_back(apply_fifo_op(op));
        ops_accepted++;
      end
    end
    // The drivers at the falling edge need to know which beats just moved.
    in_beat_done  = rst_n && in_ch.valid && in_ch.ready;
    res_beat_done = rst_n && out_ch.valid && out_ch.ready;
  end

  // ------------------------------------------------------------------
  // Input driver. Once the current beat has gone (or none was offered),
  // it waits the gap drawn for the next operation, then presents it.
  // The valid is held steadily while the block stalls.
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    fifo_op_t op;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_beat_done) begin
      if (in_wait > 0) begin
        in_wait--;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        in_ch.mode        <= op.mode;
        in_ch.push_data   <= op.push_data;
        in_ch.peek_offset <= op.peek_offset;
        in_ch.valid       <= 1'b1;
        in_wait = $urandom_range(0, in_gap_max);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Result receiver. After each beat it draws a stall and holds ready low
  // until the stall has counted down. The count also runs while nothing
  // is offered, so the stalls land on every phase of the block's work.
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (res_beat_done) out_stall = $urandom_range(0, out_stall_max);
      else if (out_stall > 0) out_stall--;
      out_ch.ready <= (out_stall == 0);
    end
  end

  task automatic queue_op(logic [MODE_W-1:0] m, logic [ELEM_W-1:0] d,
                          logic [OFFSET_W-1:0] o);
    pending_ops.push_back('{mode: m, push_data: d, peek_offset: o});
    ops_queued++;
  endtask

  // Returns at a falling edge once every operation has been accepted and
  // every result has come back. With one result per operation, the block
  // is then idle.
  task automatic wait_idle();
    do @(negedge clk);
    while (ops_accepted != ops_queued || awaited_status.size() != 0);
  endtask

  // Capacity writes happen only while no operation is in flight. The block
  // takes the write only when the buffer is empty, and then rewinds both
  // pointers; otherwise the old capacity stays.
  task automatic write_capacity(logic [CAPCFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    if (shadow_wr == shadow_rd) begin
      shadow_cap = value;
      shadow_wr  = 0;
      shadow_rd  = 0;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random operation. The push share sets whether a phase tends to
  // fill the buffer or drain it; what is left is split between pops and
  // peeks, with a small share of the unused mode.
  task automatic queue_random_op(int push_share);
    int                  r;
    logic [ELEM_W-1:0]   d;
    logic [OFFSET_W-1:0] o;
    r = $urandom_range(0, 99);
    d = $urandom;
    case ($urandom_range(0, 15))
      0: d = '0;
      1: d = '1;
      default: ;
    endcase
    // Small offsets mostly, so that many peeks land inside the count.
    o = $urandom_range(0, 1) ? OFFSET_W'($urandom_range(0, 3)) : OFFSET_W'($urandom);
    if (r < 4) queue_op(MODE_UNUSED, d, o);
    else if (r < 4 + push_share) queue_op(MODE_PUSH, d, o);
    else if (r < 4 + push_share + (96 - push_share) / 2) queue_op(MODE_POP, d, o);
    else queue_op(MODE_PEEK, d, o);
  endtask

  // ------------------------------------------------------------------
  // Stimulus.
  // ------------------------------------------------------------------
  initial begin
    logic [CAPCFG_W-1:0] cap_plan [7];
    int                  phase;
    int                  drain_n;
    cap_plan = '{5'd0, 5'd1, 5'd2, 5'd31, 5'd17, 5'd16, 5'd3};

    // Every input of the block is known from time zero.
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_PUSH;
    in_ch.push_data   = '0;
    in_ch.peek_offset = '0;
    out_ch.ready      = 1'b0;

    shadow_wr     = 0;
    shadow_rd     = 0;
    shadow_cap    = CAPCFG_W'(CAP_RESET);
    foreach (shadow_store[i]) shadow_store[i] = '0;
    ops_queued    = 0;
    ops_accepted  = 0;
    fail_count    = 0;
    in_wait       = 0;
    out_stall     = 0;
    in_gap_max    = 2;
    out_stall_max = 2;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset capacity: failures on an empty buffer,
    // the unused mode, extreme elements, peeks at the newest and oldest
    // element and just past the count, and the largest offset.
    queue_op(MODE_POP, 32'h0000_0000, 4'd0);
    queue_op(MODE_PEEK, 32'h0000_0000, 4'd0);
    queue_op(MODE_UNUSED, 32'hFFFF_FFFF, 4'd15);
    queue_op(MODE_PUSH, 32'h0000_0000, 4'd0);
    queue_op(MODE_PUSH, 32'hFFFF_FFFF, 4'd15);
    queue_op(MODE_PUSH, 32'h1234_5678, 4'd0);
    queue_op(MODE_PEEK, 32'h0000_0000, 4'd0);
    queue_op(MODE_PEEK, 32'h0000_0000, 4'd2);
    queue_op(MODE_PEEK, 32'h0000_0000, 4'd3);
    queue_op(MODE_PEEK, 32'h0000_0000, 4'd15);
    queue_op(MODE_POP, 32'h0000_0000, 4'd0);
    queue_op(MODE_UNUSED, 32'hA5A5_A5A5, 4'd5);
    wait_idle();

    // Two elements are still held, so this write must be ignored.
    write_capacity(5'd0);
    queue_op(MODE_POP, 32'h0, 4'd0);
    queue_op(MODE_POP, 32'h0, 4'd0);
    wait_idle();

    // Now empty: a capacity of one acts as two, so one element fills it.
    write_capacity(5'd1);
    queue_op(MODE_PUSH, 32'hDEAD_BEEF, 4'd0);
    queue_op(MODE_PUSH, 32'hCAFE_F00D, 4'd0);
    queue_op(MODE_PEEK, 32'h0, 4'd0);
    queue_op(MODE_PEEK, 32'h0, 4'd1);
    queue_op(MODE_POP, 32'h0, 4'd0);
    queue_op(MODE_POP, 32'h0, 4'd0);

    // Random part in phases. Each phase boundary holds the sender back
    // until every owed result has come, then often drains the buffer so
    // that the capacity write takes effect; without a drain the write
    // meets a non-empty buffer and must be ignored.
    phase = 0;
    while (ops_queued < TARGET_OPS) begin
      wait_idle();
      if ($urandom_range(0, 2) != 0) begin
        drain_n = shadow_held();
        repeat (drain_n) queue_op(MODE_POP, $urandom, OFFSET_W'($urandom));
        wait_idle();
      end
      write_capacity(phase < 7 ? cap_plan[phase] : CAPCFG_W'($urandom));
      // Some phases run with no idling at all on one or both sides.
      in_gap_max    = $urandom_range(0, 2) == 0 ? 0 : 5;
      out_stall_max = $urandom_range(0, 2) == 0 ? 0 : 5;
      repeat ($urandom_range(30, 90)) queue_random_op($urandom_range(15, 75));
      phase++;
    end

    wait_idle();
    repeat (4) @(negedge clk);
    if (awaited_status.size() != 0) begin
      fail_count++;
      $display("%0t ns: %0d results never arrived", $time, awaited_status.size());
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is far shorter than this.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/rfp_pkg.sv
rtl/rfp_in_if.sv
rtl/rfp_out_if.sv
rtl/rfp_mem.sv
rtl/rfp_ctrl.sv
rtl/ring_fifo_with_peek.sv
bench/ring_fifo_with_peek_tb.sv
